[sv/pid_step_four_variant_core_macros.svh]
// Assertion macros shared by the PID step core modules.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef PID_STEP_FOUR_VARIANT_CORE_MACROS_SVH
`define PID_STEP_FOUR_VARIANT_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PID4V_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PID4V_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pid4v_pkg.sv]
// Shared types, register codes and fixed-point constants of the PID step core.
// Used by every module of the core; depends on nothing.
`default_nettype none

package pid4v_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SETPOINT = 3'd4;

  typedef enum logic [1:0] {
    MODE_PLAIN    = 2'd0,
    MODE_SPEED    = 2'd1,
    MODE_TURN     = 2'd2,
    MODE_STRAIGHT = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [23:0] gain_p;
    logic signed [23:0] gain_i;
    logic signed [23:0] gain_d;
    logic signed [23:0] setpoint;
  } cfg_t;

  // Error constants, Q16.8.
  localparam logic signed [24:0] DEADBAND     = 25'sd128;
  localparam logic signed [25:0] HALF_TURN    = 26'sd46080;
  localparam logic signed [25:0] HALF_TURN_P1 = 26'sd46081;
  localparam logic signed [25:0] TURN_358     = 26'sd91648;
  localparam logic signed [26:0] SMALL_ERR    = 27'sd2560;

  // One full turn of 360 is 45 * 2^11 LSB; the quotient by 45 uses a reciprocal
  // of 2^20 / 45 rounded up, exact for dividends below 2^13.
  localparam logic [13:0] TURN_360_UNITS = 14'd45;
  localparam logic [14:0] RECIP_45       = 15'd23302;

  // Integral limits, Q31.8.
  localparam logic signed [39:0] SAT40_MAX  = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] SAT40_MIN  = 40'sh80_0000_0000;
  localparam logic signed [39:0] ILIM_WIDE  = 40'sd256000;
  localparam logic signed [39:0] ILIM_SMALL = 40'sd12800;

  // Output rounding and limits.
  localparam logic signed [63:0] ROUND_HALF = 64'sd2048;
  localparam logic signed [63:0] DRIVE_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] DRIVE_MIN  = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [31:0] OUT_LIM3   = 32'sd512000;

  // Error after the first two stages.
  typedef struct packed {
    logic signed [24:0] err;
    logic               gt;
    logic               lt;
    logic [7:0]         quot;
  } wrap_item_t;

  // Conditioned error handed to the integrator.
  typedef struct packed {
    logic signed [24:0] err;
    logic               clr;
    logic               err_small;
    logic               wrapped;
  } err_item_t;

  // Operands of the gain products.
  typedef struct packed {
    logic signed [24:0] err;
    logic signed [25:0] diff;
    logic signed [39:0] integ;
  } acc_item_t;

  // Partial products.
  typedef struct packed {
    logic signed [48:0] p;
    logic signed [49:0] d;
    logic signed [44:0] ilo;
    logic signed [43:0] ihi;
  } prod_t;

  // Two partial sums; their total is the Q.20 accumulator plus the rounding half.
  typedef struct packed {
    logic signed [63:0] s1;
    logic signed [63:0] s2;
  } sum_item_t;

endpackage

`default_nettype wire

[sv/pid4v_prep.sv]
// Error conditioning stages: error subtraction, wrap quotient, per-mode conditioning.
// Depends on pid4v_pkg and the core's assertion macro header.
`default_nettype none
`include "pid_step_four_variant_core_macros.svh"

module pid4v_prep (
  input  logic                  clk,
  input  logic                  rst,
  input  pid4v_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [23:0]    in_meas,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid4v_pkg::err_item_t  out_item
);

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready;
  logic signed [24:0] a_err;
  pid4v_pkg::wrap_item_t b_item, b_next;
  pid4v_pkg::err_item_t c_item, c_next;

  logic signed [25:0] a_ext, t_above, t_below;
  logic [23:0] t_sel;
  logic [27:0] quot_prod;

  logic [8:0] k;
  logic [13:0] span_units;
  logic signed [26:0] b_ext, span, e_wrap360;
  logic signed [25:0] e_wrap358;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  // Quotient of the excess over half a turn by a full turn of 360.
  always_comb begin
    a_ext   = 26'(a_err);
    t_above = a_ext - pid4v_pkg::HALF_TURN_P1;
    t_below = -pid4v_pkg::HALF_TURN_P1 - a_ext;
    b_next.err = a_err;
    b_next.gt  = a_ext > pid4v_pkg::HALF_TURN;
    b_next.lt  = a_ext < -pid4v_pkg::HALF_TURN;
    t_sel      = b_next.gt ? t_above[23:0] : t_below[23:0];
    quot_prod  = 28'(t_sel[23:11]) * 28'(pid4v_pkg::RECIP_45);
    b_next.quot = quot_prod[27:20];
  end

  always_comb begin
    k          = 9'(b_item.quot) + 9'd1;
    span_units = 14'(k) * pid4v_pkg::TURN_360_UNITS;
    span       = 27'({span_units, 11'b0});
    b_ext      = 27'(b_item.err);
    e_wrap360  = b_item.gt ? b_ext - span : (b_item.lt ? b_ext + span : b_ext);
    e_wrap358  = b_item.gt ? 26'(b_item.err) - pid4v_pkg::TURN_358 :
                 (b_item.lt ? 26'(b_item.err) + pid4v_pkg::TURN_358 : 26'(b_item.err));
    c_next = '0;
    unique case (cfg.mode)
      pid4v_pkg::MODE_PLAIN: begin
        c_next.err = b_item.err;
      end
      pid4v_pkg::MODE_SPEED: begin
        if (b_item.err < pid4v_pkg::DEADBAND && b_item.err > -pid4v_pkg::DEADBAND) begin
          c_next.err = '0;
        end else begin
          c_next.err = b_item.err;
        end
      end
      pid4v_pkg::MODE_TURN: begin
        // A value still a full turn out after one wrap drops the error and the integral.
        if (e_wrap358 >= pid4v_pkg::TURN_358 || e_wrap358 <= -pid4v_pkg::TURN_358) begin
          c_next.err = '0;
          c_next.clr = 1'b1;
        end else begin
          c_next.err = e_wrap358[24:0];
        end
      end
      pid4v_pkg::MODE_STRAIGHT: begin
        c_next.err       = e_wrap360[24:0];
        c_next.wrapped   = 1'b1;
        c_next.err_small = e_wrap360 < pid4v_pkg::SMALL_ERR &&
                           e_wrap360 > -pid4v_pkg::SMALL_ERR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        b_valid <= a_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
    if (a_ready && in_valid) begin
      a_err <= 25'(cfg.setpoint) - 25'(in_meas);
    end
    if (b_ready && a_valid) begin
      b_item <= b_next;
    end
    if (c_ready && b_valid) begin
      c_item <= c_next;
    end
  end

  assign out_valid = c_valid;
  assign out_item  = c_item;

  // A wrapped error always lands within half a turn, both ends included.
  `PID4V_IMPLIES(a_wrap_range, clk, rst, c_valid && c_item.wrapped, c_item.err <= pid4v_pkg::HALF_TURN && c_item.err >= -pid4v_pkg::HALF_TURN, "wrapped error outside half a turn")

endmodule

`default_nettype wire

[sv/pid4v_integ.sv]
// Integrator stage: holds the running integral and the previous error.
// Depends on pid4v_pkg and the core's assertion macro header.
`default_nettype none
`include "pid_step_four_variant_core_macros.svh"

module pid4v_integ (
  input  logic                  clk,
  input  logic                  rst,
  input  pid4v_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pid4v_pkg::err_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid4v_pkg::acc_item_t  out_item
);

  logic signed [39:0] integral_sum, integ_next;
  logic signed [24:0] previous_error;
  logic signed [40:0] base, sum;
  logic d_valid, upd;
  pid4v_pkg::acc_item_t d_item, d_next;

  assign in_ready = !d_valid || out_ready;
  assign upd      = in_valid && in_ready;

  always_comb begin
    base = in_item.clr ? '0 : 41'(integral_sum);
    sum  = base + 41'(in_item.err);
    unique case (cfg.mode)
      pid4v_pkg::MODE_PLAIN: begin
        if (sum > pid4v_pkg::SAT40_MAX) begin
          integ_next = pid4v_pkg::SAT40_MAX;
        end else if (sum < pid4v_pkg::SAT40_MIN) begin
          integ_next = pid4v_pkg::SAT40_MIN;
        end else begin
          integ_next = sum[39:0];
        end
      end
      pid4v_pkg::MODE_SPEED, pid4v_pkg::MODE_TURN: begin
        if (sum > pid4v_pkg::ILIM_WIDE) begin
          integ_next = pid4v_pkg::ILIM_WIDE;
        end else if (sum < -pid4v_pkg::ILIM_WIDE) begin
          integ_next = -pid4v_pkg::ILIM_WIDE;
        end else begin
          integ_next = sum[39:0];
        end
      end
      pid4v_pkg::MODE_STRAIGHT: begin
        // Integrate only near the target; a large error clears the integral.
        if (!in_item.err_small) begin
          integ_next = '0;
        end else if (sum > pid4v_pkg::ILIM_SMALL) begin
          integ_next = pid4v_pkg::ILIM_SMALL;
        end else if (sum < -pid4v_pkg::ILIM_SMALL) begin
          integ_next = -pid4v_pkg::ILIM_SMALL;
        end else begin
          integ_next = sum[39:0];
        end
      end
    endcase
    d_next.err   = in_item.err;
    d_next.diff  = 26'(in_item.err) - 26'(previous_error);
    d_next.integ = integ_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid        <= 1'b0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      if (in_ready) begin
        d_valid <= in_valid;
      end
      if (upd) begin
        integral_sum   <= integ_next;
        previous_error <= in_item.err;
      end
    end
    if (upd) begin
      d_item <= d_next;
    end
  end

  assign out_valid = d_valid;
  assign out_item  = d_item;

  // The state moves only once per word, when the word enters this stage.
  `PID4V_IMPLIES_NEXT(a_state_hold, clk, rst, !upd, $stable(integral_sum) && $stable(previous_error), "state changed without a word passing")
  `PID4V_IMPLIES_NEXT(a_integ_small, clk, rst, upd && cfg.mode == pid4v_pkg::MODE_STRAIGHT, integral_sum <= pid4v_pkg::ILIM_SMALL && integral_sum >= -pid4v_pkg::ILIM_SMALL, "straight integral beyond its limit")
  `PID4V_IMPLIES_NEXT(a_integ_wide, clk, rst, upd && (cfg.mode == pid4v_pkg::MODE_SPEED || cfg.mode == pid4v_pkg::MODE_TURN), integral_sum <= pid4v_pkg::ILIM_WIDE && integral_sum >= -pid4v_pkg::ILIM_WIDE, "clamped integral beyond its limit")

endmodule

`default_nettype wire

[sv/pid4v_mac.sv]
// Gain multiply and partial sum stages of the PID step core.
// Depends on pid4v_pkg.
`default_nettype none

module pid4v_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  pid4v_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pid4v_pkg::acc_item_t  in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pid4v_pkg::sum_item_t  out_item
);

  logic e_valid, f_valid;
  logic e_ready, f_ready;
  pid4v_pkg::prod_t e_item, e_next;
  pid4v_pkg::sum_item_t f_item, f_next;

  assign f_ready  = !f_valid || out_ready;
  assign e_ready  = !e_valid || f_ready;
  assign in_ready = e_ready;

  // The 40-bit integral is split in two 20-bit halves to keep each product narrow.
  always_comb begin
    e_next.p   = 49'(cfg.gain_p) * 49'(in_item.err);
    e_next.d   = 50'(cfg.gain_d) * 50'(in_item.diff);
    e_next.ilo = 45'(cfg.gain_i) * 45'($signed({1'b0, in_item.integ[19:0]}));
    e_next.ihi = 44'(cfg.gain_i) * 44'($signed(in_item.integ[39:20]));
  end

  always_comb begin
    f_next.s1 = 64'(e_item.p) + 64'(e_item.d) + pid4v_pkg::ROUND_HALF;
    f_next.s2 = (64'(e_item.ihi) <<< 20) + 64'(e_item.ilo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid <= in_valid;
      end
      if (f_ready) begin
        f_valid <= e_valid;
      end
    end
    if (e_ready && in_valid) begin
      e_item <= e_next;
    end
    if (f_ready && e_valid) begin
      f_item <= f_next;
    end
  end

  assign out_valid = f_valid;
  assign out_item  = f_item;

endmodule

`default_nettype wire

[sv/pid_step_four_variant_core.sv]
// Top level of the four-variant positional PID step core.
// Depends on pid4v_pkg, pid4v_prep, pid4v_integ and pid4v_mac.
//
// Usage:
// Each word on the slave stream carries one measured value (signed Q15.8). The
// core forms error = setpoint - measured, conditions it according to the mode
// register, updates the running integral and the stored previous error, and
// sends one word on the master stream: the drive, kp*e + ki*integral +
// kd*(e - previous e), rounded half up to Q23.8 and saturated to 32 bits.
// Registers are set through the write port (index 0 mode, 1..3 gains, 4
// setpoint); writes to other indexes are dropped. Write them only while no
// word is in flight.
// The core takes one word per cycle, back to back, while the receiver keeps up,
// through seven pipeline registers; the integral and previous error update in
// one stage, so a word sees the state left by the word just ahead of it.
// Each stage holds its word while the stage after it is full, so a stalled
// receiver fills the pipeline and only then drops s_axis_tready; bubbles are
// squeezed out. Reset clears the registers, the integral, the previous error
// and the pipeline; any word in flight is lost.
`default_nettype none

module pid_step_four_variant_core (
  input  logic        clk,
  input  logic        rst,
  // Slave stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] measured
  // Master stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  // Register write port.
  input  logic                              cfg_we,
  input  logic [pid4v_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pid4v_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pid4v_pkg::cfg_t cfg;

  logic prep_valid, prep_ready;
  pid4v_pkg::err_item_t prep_item;
  logic integ_valid, integ_ready;
  pid4v_pkg::acc_item_t integ_item;
  logic mac_valid, mac_ready;
  pid4v_pkg::sum_item_t mac_item;

  logic o_valid;
  logic signed [31:0] o_drive, drive_next, drive_sat;
  logic signed [63:0] acc, acc_q8;

  // Register file. Writes to unused indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pid4v_pkg::REG_MODE:     cfg.mode     <= pid4v_pkg::mode_t'(cfg_data[1:0]);
        pid4v_pkg::REG_GAIN_P:   cfg.gain_p   <= $signed(cfg_data);
        pid4v_pkg::REG_GAIN_I:   cfg.gain_i   <= $signed(cfg_data);
        pid4v_pkg::REG_GAIN_D:   cfg.gain_d   <= $signed(cfg_data);
        pid4v_pkg::REG_SETPOINT: cfg.setpoint <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Three stages of error conditioning.
  pid4v_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_meas   ($signed(s_axis_tdata)),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_item  (prep_item)
  );

  // Integral and previous error update.
  pid4v_integ u_integ (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_item   (prep_item),
    .out_valid (integ_valid),
    .out_ready (integ_ready),
    .out_item  (integ_item)
  );

  // Gain products and partial sums.
  pid4v_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (integ_valid),
    .in_ready  (integ_ready),
    .in_item   (integ_item),
    .out_valid (mac_valid),
    .out_ready (mac_ready),
    .out_item  (mac_item)
  );

  // Final add, then a floor shift by 12 bits completes the round half up to
  // Q.8. The result saturates to 32 bits, and the straight mode adds its own
  // tighter output limit on top.
  always_comb begin
    acc    = mac_item.s1 + mac_item.s2;
    acc_q8 = acc >>> 12;
    if (acc_q8 > pid4v_pkg::DRIVE_MAX) begin
      drive_sat = pid4v_pkg::DRIVE_MAX[31:0];
    end else if (acc_q8 < pid4v_pkg::DRIVE_MIN) begin
      drive_sat = pid4v_pkg::DRIVE_MIN[31:0];
    end else begin
      drive_sat = acc_q8[31:0];
    end
    drive_next = drive_sat;
    if (cfg.mode == pid4v_pkg::MODE_STRAIGHT) begin
      if (drive_sat > pid4v_pkg::OUT_LIM3) begin
        drive_next = pid4v_pkg::OUT_LIM3;
      end else if (drive_sat < -pid4v_pkg::OUT_LIM3) begin
        drive_next = -pid4v_pkg::OUT_LIM3;
      end
    end
  end

  // Output register: the word waits here while the receiver stalls.
  assign mac_ready = !o_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (mac_ready) begin
      o_valid <= mac_valid;
    end
    if (mac_ready && mac_valid) begin
      o_drive <= drive_next;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_drive;

endmodule

`default_nettype wire

[tb/pid4v_tb_pkg.sv]
`timescale 1ns / 100ps
// Drive predictor and result scoreboard for the PID step core testbench.
// Depends on pid4v_pkg for the register indexes and the mode codes.
package pid4v_tb_pkg;

  localparam longint ERR_DEADBAND  = 128;
  localparam longint ERR_HALF_TURN = 46080;
  localparam longint ERR_TURN_358  = 91648;
  localparam longint ERR_TURN_360  = 92160;
  localparam longint ERR_SMALL     = 2560;
  localparam longint INTEG_MAX     = 64'sh0000_007F_FFFF_FFFF;
  localparam longint INTEG_MIN     = -INTEG_MAX - 1;
  localparam longint INTEG_WIDE    = 256000;
  localparam longint INTEG_NARROW  = 12800;
  localparam longint ROUND_Q20     = 2048;
  localparam longint DRIVE_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint DRIVE_MIN     = -DRIVE_MAX - 1;
  localparam longint DRIVE_LIM_STR = 512000;
  localparam int     SHOWN_ERRORS  = 40;

  class drive_scoreboard;
    pid4v_pkg::mode_t   mode;
    logic signed [23:0] kp, ki, kd, target;
    logic signed [39:0] integral;
    logic signed [24:0] last_err;
    logic [31:0]        drive_q[$];
    int                 mismatches;
    int                 words_seen;

    function new();
      mode       = pid4v_pkg::MODE_PLAIN;
      kp         = '0;
      ki         = '0;
      kd         = '0;
      target     = '0;
      integral   = '0;
      last_err   = '0;
      mismatches = 0;
      words_seen = 0;
    endfunction

    function longint clamp(longint x, longint lo, longint hi);
      return (x > hi) ? hi : ((x < lo) ? lo : x);
    endfunction

    // Mirrors a register write; indexes above the setpoint are dropped.
    function void write_reg(logic [pid4v_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] data);
      case (idx)
        pid4v_pkg::REG_MODE:     mode = pid4v_pkg::mode_t'(data[1:0]);
        pid4v_pkg::REG_GAIN_P:   kp = data;
        pid4v_pkg::REG_GAIN_I:   ki = data;
        pid4v_pkg::REG_GAIN_D:   kd = data;
        pid4v_pkg::REG_SETPOINT: target = data;
        default: ;
      endcase
    endfunction

    // One controller step: condition the error, update the integral, form the drive.
    function logic [31:0] predict_drive(logic [23:0] meas_bits);
      longint err, integ, acc, res, turns;
      err   = longint'(target) - longint'($signed(meas_bits));
      integ = longint'(integral);
      case (mode)
        pid4v_pkg::MODE_PLAIN: begin
          integ = clamp(integ + err, INTEG_MIN, INTEG_MAX);
        end
        pid4v_pkg::MODE_SPEED: begin
          if (err < ERR_DEADBAND && err > -ERR_DEADBAND) err = 0;
          integ = clamp(integ + err, -INTEG_WIDE, INTEG_WIDE);
        end
        pid4v_pkg::MODE_TURN: begin
          if (err > ERR_HALF_TURN) err -= ERR_TURN_358;
          else if (err < -ERR_HALF_TURN) err += ERR_TURN_358;
          // Still a whole turn or more away: start over from zero.
          if (err >= ERR_TURN_358 || err <= -ERR_TURN_358) begin
            err   = 0;
            integ = 0;
          end
          integ = clamp(integ + err, -INTEG_WIDE, INTEG_WIDE);
        end
        default: begin
          if (err > ERR_HALF_TURN) begin
            turns = (err - ERR_HALF_TURN + ERR_TURN_360 - 1) / ERR_TURN_360;
            err  -= turns * ERR_TURN_360;
          end else if (err < -ERR_HALF_TURN) begin
            turns = (-ERR_HALF_TURN - err + ERR_TURN_360 - 1) / ERR_TURN_360;
            err  += turns * ERR_TURN_360;
          end
          if (err < ERR_SMALL && err > -ERR_SMALL)
            integ = clamp(integ + err, -INTEG_NARROW, INTEG_NARROW);
          else
            integ = 0;
        end
      endcase
      acc = longint'(kp) * err + longint'(ki) * integ
          + longint'(kd) * (err - longint'(last_err));
      res = (acc + ROUND_Q20) >>> 12;
      res = clamp(res, DRIVE_MIN, DRIVE_MAX);
      if (mode == pid4v_pkg::MODE_STRAIGHT) res = clamp(res, -DRIVE_LIM_STR, DRIVE_LIM_STR);
      integral = integ[39:0];
      last_err = err[24:0];
      return res[31:0];
    endfunction

    function void note_measured(logic [23:0] meas_bits);
      drive_q.push_back(predict_drive(meas_bits));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < SHOWN_ERRORS) $display("%t mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_drive(logic [31:0] got);
      logic [31:0] want;
      words_seen++;
      if (drive_q.size() == 0) begin
        report_mismatch($sformatf("drive word %0d (%0d) arrived with none outstanding",
                                  words_seen, $signed(got)));
      end else begin
        want = drive_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("drive word %0d: got %0d, want %0d",
                                    words_seen, $signed(got), $signed(want)));
      end
    endtask
  endclass

endpackage

[tb/tb_pid_step_four_variant_core.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the four-variant PID step core.
// Depends on pid4v_pkg, pid4v_tb_pkg and the core pid_step_four_variant_core.
module tb_pid_step_four_variant_core;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, well past pipeline depth
  localparam int SETTLE_WAIT  = 20;      // settling wait after the last word
  localparam int LIMIT_CYCLES = 1000000;
  localparam int SOAK_WORDS   = 200;     // enough full-scale errors to run far past the wide limit
  localparam logic [pid4v_pkg::CFG_INDEX_W-1:0] CFG_INDEX_TOP = '1;

  typedef logic [pid4v_pkg::CFG_INDEX_W-1:0] cfg_index_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic                              cfg_we = 1'b0;
  logic [pid4v_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [pid4v_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Idling switch shared by sender and receiver; the hold, soak and final phases turn it off.
  bit idle_on  = 1'b1;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 1'b0;

  pid4v_tb_pkg::drive_scoreboard sb = new();

  pid_step_four_variant_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Both monitors sample at the rising edge, before any nonblocking update of that
  // edge lands, so a word counts exactly when the core sees the handshake.
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_measured(s_axis_tdata);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_drive(m_axis_tdata);
  end

  // Receiver: random stall bursts, one long hold-off on request, otherwise ready.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one measured word, possibly after an idle burst, and returns on the
  // edge that accepts it. The valid stays high so the next word follows back to back.
  task automatic send_word(input logic [23:0] value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Drops the valid and waits until every outstanding drive word has been checked.
  // Each word yields exactly one drive, so an empty store means an empty pipeline.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [pid4v_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Writes all five registers, plus one write to an unused index that must be dropped.
  // The mode word carries random upper bits, which the core ignores.
  task automatic configure(input pid4v_pkg::mode_t m, input logic [23:0] kp,
                           input logic [23:0] ki, input logic [23:0] kd,
                           input logic [23:0] sp);
    logic [23:0] mode_word;
    mode_word      = 24'($urandom);
    mode_word[1:0] = m;
    write_reg(pid4v_pkg::REG_MODE, mode_word);
    write_reg(pid4v_pkg::REG_GAIN_P, kp);
    write_reg(cfg_index_t'($urandom_range(pid4v_pkg::REG_SETPOINT + 1, CFG_INDEX_TOP)),
              24'($urandom));
    write_reg(pid4v_pkg::REG_GAIN_I, ki);
    write_reg(pid4v_pkg::REG_GAIN_D, kd);
    write_reg(pid4v_pkg::REG_SETPOINT, sp);
    cfg_we <= 1'b0;
  endtask

  // Gains mix small values and full-range random ones, with the extremes mixed in.
  function automatic logic [23:0] rand_gain();
    case ($urandom_range(0, 9))
      0: return 24'h7F_FFFF;
      1: return 24'h80_0000;
      2: return 24'h00_0000;
      3, 4, 5: return 24'(int'($urandom_range(0, 16384)) - 8192);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] rand_setpoint();
    case ($urandom_range(0, 5))
      0: return 24'h00_0000;
      1: return 24'h7F_FFFF;
      2: return 24'h80_0000;
      default: return 24'($urandom);
    endcase
  endfunction

  // Picks an error near one of the thresholds (deadband, half turn, whole turns of
  // 358 and 360, the small-error window) and turns it into a measured value.
  function automatic logic [23:0] rand_measured(input logic [23:0] sp);
    int err;
    case ($urandom_range(0, 6))
      0: return 24'($urandom);
      1: err = int'($urandom_range(0, 600)) - 300;
      2: err = 46080 + int'($urandom_range(0, 600)) - 300;
      3: err = ($urandom_range(0, 1) ? 91648 : 137728) + int'($urandom_range(0, 600)) - 300;
      4: err = 92160 * int'($urandom_range(0, 90)) + int'($urandom_range(0, 6000)) - 3000;
      5: err = 2560 + int'($urandom_range(0, 600)) - 300;
      default: err = int'($urandom_range(0, 40000)) - 20000;
    endcase
    if ($urandom_range(0, 1)) err = -err;
    return sp - 24'(err);
  endfunction

  task automatic random_phase(input int count, input bit fixed_mode,
                              input pid4v_pkg::mode_t m);
    pid4v_pkg::mode_t pick;
    logic [23:0]      sp;
    pick = fixed_mode ? m : pid4v_pkg::mode_t'($urandom_range(0, 3));
    sp   = rand_setpoint();
    configure(pick, rand_gain(), rand_gain(), rand_gain(), sp);
    repeat (count) send_word(rand_measured(sp));
    finish_phase();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: all gains zero, so every drive is zero.
    send_word(24'h7F_FFFF);
    send_word(24'h80_0000);
    finish_phase();

    // Plain mode with small gains, then full-scale gains and errors to hit the
    // 32-bit drive saturation from both sides.
    configure(pid4v_pkg::MODE_PLAIN, 24'd4096, 24'd16, -24'sd4096, 24'd0);
    send_word(24'h00_0000);
    send_word(24'h7F_FFFF);
    send_word(24'h80_0000);
    finish_phase();
    configure(pid4v_pkg::MODE_PLAIN, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h7F_FFFF);
    send_word(24'h80_0000);
    send_word(24'h80_0000);
    send_word(24'h7F_FFFF);
    finish_phase();

    // Speed mode: errors just inside and just outside the 0.5 deadband, then a
    // full-scale error that runs into the integral clamp.
    configure(pid4v_pkg::MODE_SPEED, 24'd4096, 24'd4096, 24'd0, 24'd0);
    send_word(24'd127);
    send_word(-24'sd127);
    send_word(24'd128);
    send_word(-24'sd128);
    send_word(24'h80_0000);
    finish_phase();

    // Turn mode: exactly half a turn stays, one LSB past it wraps by 358, and
    // errors still a whole turn away after the wrap clear error and integral.
    configure(pid4v_pkg::MODE_TURN, 24'd4096, 24'd2048, 24'd1024, 24'd0);
    send_word(-24'sd46080);
    send_word(-24'sd46081);
    send_word(24'd46081);
    send_word(-24'sd137729);
    send_word(24'h80_0000);
    send_word(24'h7F_FFFF);
    finish_phase();

    // Straight mode: the 180 boundary on both sides, the 10 degree integration
    // window, a many-turn error, and a large gain that meets the 2000 drive clamp.
    configure(pid4v_pkg::MODE_STRAIGHT, 24'h7F_FFFF, 24'd4096, 24'h80_0000, 24'd0);
    send_word(-24'sd46080);
    send_word(-24'sd46081);
    send_word(24'd46081);
    send_word(-24'sd2559);
    send_word(-24'sd2560);
    send_word(24'h80_0000);
    finish_phase();

    // Random phases with idling on both sides.
    repeat (6) random_phase($urandom_range(80, 120), 1'b0, pid4v_pkg::MODE_PLAIN);

    // The receiver holds off while the sender keeps offering words, so the
    // pipeline fills and the core must drop s_axis_tready.
    idle_on  = 1'b0;
    hold_req = 1'b1;
    random_phase(140, 1'b0, pid4v_pkg::MODE_PLAIN);
    idle_on  = 1'b1;

    repeat (4) random_phase($urandom_range(80, 120), 1'b0, pid4v_pkg::MODE_PLAIN);

    // Near full-scale positive errors in plain mode grow the integral far past the
    // wide limit; the speed phase after it then inherits and clamps that integral.
    idle_on = 1'b0;
    configure(pid4v_pkg::MODE_PLAIN, rand_gain(), rand_gain(), rand_gain(), 24'h7F_FFFF);
    repeat (SOAK_WORDS) send_word(24'h80_0000 | 24'($urandom_range(0, 255)));
    finish_phase();
    idle_on = 1'b1;
    random_phase(120, 1'b1, pid4v_pkg::MODE_SPEED);

    repeat (2) random_phase($urandom_range(80, 120), 1'b0, pid4v_pkg::MODE_PLAIN);

    // Last part of the run: no idling anywhere, every mode once.
    idle_on = 1'b0;
    random_phase(60, 1'b1, pid4v_pkg::MODE_PLAIN);
    random_phase(60, 1'b1, pid4v_pkg::MODE_SPEED);
    random_phase(60, 1'b1, pid4v_pkg::MODE_TURN);
    random_phase(60, 1'b1, pid4v_pkg::MODE_STRAIGHT);

    // Any drive word that shows up now has no word behind it and is reported.
    repeat (SETTLE_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(longint'(CLK_PERIOD) * LIMIT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
